// ----- design/assert_macros.svh -----
// assertion macros used by the transform generator design file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define KFAT_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define KFAT_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- design/kfat_pkg.sv -----
// shared constants, types and helper functions of the keyframe transform generator
package kfat_pkg;

  // table geometry
  localparam int MAX_KEYFRAMES = 16;
  localparam int KF_AW         = $clog2(MAX_KEYFRAMES);
  localparam int VAL_W         = 32;
  localparam int ENTRY_W       = 3 * VAL_W + 2;
  localparam int FRAC_BITS     = 16;

  // interpolation
  localparam int SP_W   = 22;
  localparam int IP_W   = 56;

  // angle reduction: period is 45 << (FRAC_BITS + 3)
  localparam int LOW_W    = FRAC_BITS + 3;
  localparam int H_W      = VAL_W - LOW_W;
  localparam int H_OFS    = 45 * ((1 << (H_W - 1)) / 45 + 1);
  localparam int HU_W     = H_W + 1;
  localparam int RECIP_SH = HU_W + 2;
  localparam int RECIP    = (1 << RECIP_SH) / 45;
  localparam int HP_W     = HU_W + RECIP_SH;
  localparam int R0_W     = LOW_W + 6;
  localparam int MAG_W    = FRAC_BITS + 7;
  localparam int MM_W     = MAG_W + 27;

  localparam logic [R0_W-1:0] DEG_90  = R0_W'(90) << FRAC_BITS;
  localparam logic [R0_W-1:0] DEG_180 = R0_W'(180) << FRAC_BITS;
  localparam logic [R0_W-1:0] DEG_270 = R0_W'(270) << FRAC_BITS;
  localparam logic [R0_W-1:0] DEG_360 = R0_W'(360) << FRAC_BITS;

  // round(pi / 180 * 2^32)
  localparam logic [26:0] RAD_PER_DEG = 27'd74961321;

  // cordic
  localparam int CORDIC_STEPS = 24;
  localparam int TRIG_W       = 34;
  localparam logic signed [TRIG_W-1:0] CORDIC_GAIN = 34'sh26DD3B6A;
  localparam logic signed [TRIG_W-1:0] TRIG_HALF   = TRIG_W'(1) << (30 - FRAC_BITS - 1);

  // tangent divider
  localparam int QW    = 31;
  localparam int NUM_W = TRIG_W + FRAC_BITS;
  localparam int DR_W  = TRIG_W + 1;
  localparam int OV_W  = TRIG_W + QW - FRAC_BITS;
  localparam int PROD_W = TRIG_W + VAL_W;

  localparam logic signed [31:0] S32_MAX = 32'sh7FFFFFFF;
  localparam logic signed [31:0] S32_MIN = 32'sh80000000;
  localparam logic signed [31:0] FX_ONE  = 32'sd1 <<< FRAC_BITS;

  // item and register codes
  localparam logic REQ_WRITE = 1'b0;
  localparam logic REQ_EVAL  = 1'b1;
  localparam logic CFG_KIND  = 1'b0;
  localparam logic CFG_NKEY  = 1'b1;

  typedef enum logic [2:0] {
    KIND_TRANSLATE = 3'd0,
    KIND_SCALE     = 3'd1,
    KIND_ROTATE    = 3'd2,
    KIND_SKEW_X    = 3'd3,
    KIND_SKEW_Y    = 3'd4
  } kind_t;

  // saturate a wide signed value to 32 bits
  function automatic logic signed [31:0] sat32(input logic signed [71:0] v);
    if (v > 72'sd2147483647) begin
      return S32_MAX;
    end else if (v < -72'sd2147483648) begin
      return S32_MIN;
    end
    return v[31:0];
  endfunction

  // arctangent of 2^-i in Q2.30
  function automatic logic signed [TRIG_W-1:0] atan_q30(input int i);
    logic signed [TRIG_W-1:0] a;
    a = '0;
    unique case (i)
      0:  a = 34'sh3243F6A8;
      1:  a = 34'sh1DAC6705;
      2:  a = 34'sh0FADBAFC;
      3:  a = 34'sh07F56EA6;
      4:  a = 34'sh03FEAB76;
      5:  a = 34'sh01FFD55B;
      6:  a = 34'sh00FFFAAA;
      7:  a = 34'sh007FFF55;
      8:  a = 34'sh003FFFEA;
      9:  a = 34'sh001FFFFD;
      10: a = 34'sh000FFFFF;
      11: a = 34'sh0007FFFF;
      12: a = 34'sh0003FFFF;
      13: a = 34'sh0001FFFF;
      14: a = 34'sh0000FFFF;
      15: a = 34'sh00007FFF;
      16: a = 34'sh00003FFF;
      17: a = 34'sh00001FFF;
      18: a = 34'sh00000FFF;
      19: a = 34'sh000007FF;
      20: a = 34'sh000003FF;
      21: a = 34'sh000001FF;
      22: a = 34'sh000000FF;
      default: a = 34'sh0000007F;
    endcase
    return a;
  endfunction

endpackage

// ----- design/kfat_ram.sv -----
// generic ram, one write port and two registered read ports
module kfat_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr_a,
  input  logic [AW-1:0]    raddr_b,
  output logic [WIDTH-1:0] rdata_a,
  output logic [WIDTH-1:0] rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write and registered reads
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_a <= mem[raddr_a];
      rdata_b <= mem[raddr_b];
    end
  end

endmodule

// ----- design/keyframe_affine_transform_gen.sv -----
// keyframe affine transform generator: table, interpolation, cordic, matrix build
// a result passes stages 1 to 7, the cordic, the tangent divider, final 1 and the output register
// throughput: one item per cycle when not stalled, set by the fully pipelined cordic and tangent divider
// write items update the table at their accept edge and give no result
// stalls freeze the whole pipeline; synchronous reset clears valids and config
`include "assert_macros.svh"
module keyframe_affine_transform_gen
  import kfat_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic [4:0]         cfg_wdata,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_req_type,
  input  logic [3:0]         in_key_index,
  input  logic [1:0]         in_value_count,
  input  logic signed [31:0] in_value_first,
  input  logic signed [31:0] in_value_second,
  input  logic signed [31:0] in_value_third,
  input  logic [16:0]        in_progress,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] out_mat_a,
  output logic signed [31:0] out_mat_b,
  output logic signed [31:0] out_mat_c,
  output logic signed [31:0] out_mat_d,
  output logic signed [31:0] out_mat_e,
  output logic signed [31:0] out_mat_f
);

  typedef struct packed {
    logic [2:0]         kind;
    logic               none;
    logic [1:0]         cnt;
    logic signed [31:0] v0;
    logic signed [31:0] v1;
    logic signed [31:0] v2;
    logic               flip;
  } side_t;

  typedef struct packed {
    logic signed [TRIG_W-1:0] s30;
    logic signed [TRIG_W-1:0] c30;
    logic [TRIG_W-1:0]        den;
    logic                     ovf;
    logic                     czero;
    logic                     sneg;
    logic                     qneg;
  } trig_t;

  logic       adv;
  logic       out_valid_r;
  logic [2:0] kind_r;
  logic [4:0] nkey_r;

  assign adv      = !out_valid_r || out_ready;
  assign in_ready = adv;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kind_r <= 3'd0;
      nkey_r <= 5'd0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_KIND: kind_r <= cfg_wdata[2:0];
        CFG_NKEY: nkey_r <= cfg_wdata;
      endcase
    end
  end

  // ---------------------------------------------------------------- accept
  logic [4:0]          n_cl;
  logic [4:0]          segs;
  logic [SP_W-1:0]     sp;
  logic [5:0]          idx_raw;
  logic [4:0]          idx5;
  logic [KF_AW-1:0]    raddr_a;
  logic [KF_AW-1:0]    raddr_b;
  logic [SP_W-1:0]     t_nxt;
  logic                wr_en;
  logic [ENTRY_W-1:0]  wr_data;
  logic [ENTRY_W-1:0]  rd_a;
  logic [ENTRY_W-1:0]  rd_b;
  logic                v1_nxt;

  // segment pick and fraction
  always_comb begin
    n_cl    = (nkey_r > 5'(MAX_KEYFRAMES)) ? 5'(MAX_KEYFRAMES) : nkey_r;
    segs    = n_cl - 5'd1;
    sp      = SP_W'(in_progress) * SP_W'(segs);
    idx_raw = sp[SP_W-1:16];
    idx5    = (idx_raw > 6'(segs - 5'd1)) ? (segs - 5'd1) : idx_raw[4:0];
    if (n_cl < 5'd2) begin
      idx5 = 5'd0;
    end
    raddr_a = idx5[KF_AW-1:0];
    raddr_b = raddr_a + KF_AW'(1);
    t_nxt   = sp - (SP_W'(idx5) << 16);
  end

  // keyframe write, values past the count stored as zero
  always_comb begin
    wr_en   = in_valid && in_ready && (in_req_type == REQ_WRITE) &&
              (5'(in_key_index) < 5'(MAX_KEYFRAMES));
    wr_data = {in_value_count,
               (in_value_count > 2'd2) ? in_value_third  : 32'sd0,
               (in_value_count > 2'd1) ? in_value_second : 32'sd0,
               (in_value_count > 2'd0) ? in_value_first  : 32'sd0};
    v1_nxt  = in_valid && in_ready && (in_req_type == REQ_EVAL);
  end

  kfat_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (MAX_KEYFRAMES)
  ) u_table (
    .clk     (clk),
    .we      (wr_en),
    .waddr   (in_key_index[KF_AW-1:0]),
    .wdata   (wr_data),
    .re      (adv),
    .raddr_a (raddr_a),
    .raddr_b (raddr_b),
    .rdata_a (rd_a),
    .rdata_b (rd_b)
  );

  // ---------------------------------------------------------------- stage 1
  logic            v1_r;
  logic [SP_W-1:0] s1_t_r;
  logic            s1_none_r;
  logic            s1_one_r;
  logic [2:0]      s1_kind_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_t_r    <= t_nxt;
      s1_none_r <= (n_cl == 5'd0);
      s1_one_r  <= (n_cl == 5'd1);
      s1_kind_r <= kind_r;
    end
  end

  // interpolation products
  logic signed [IP_W-1:0] prod_nxt [3];
  logic signed [31:0]     a_val [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      a_val[i]    = rd_a[32*i +: 32];
      prod_nxt[i] = $signed(33'(signed'(rd_b[32*i +: 32])) - 33'(signed'(rd_a[32*i +: 32])))
                    * $signed({1'b0, s1_t_r});
    end
  end

  // ---------------------------------------------------------------- stage 2
  logic                   v2_r;
  logic signed [IP_W-1:0] s2_prod_r [3];
  logic signed [31:0]     s2_a_r [3];
  logic [1:0]             s2_la_r;
  logic [1:0]             s2_lb_r;
  logic                   s2_one_r;
  logic                   s2_none_r;
  logic [2:0]             s2_kind_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_prod_r <= prod_nxt;
      s2_a_r    <= a_val;
      s2_la_r   <= rd_a[ENTRY_W-1 -: 2];
      s2_lb_r   <= rd_b[ENTRY_W-1 -: 2];
      s2_one_r  <= s1_one_r;
      s2_none_r <= s1_none_r;
      s2_kind_r <= s1_kind_r;
    end
  end

  // rounded value and count
  logic signed [IP_W-1:0] rsh [3];
  logic signed [31:0]     v_nxt [3];
  side_t                  s3_nxt;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      rsh[i]   = (s2_prod_r[i] + 56'sd32768) >>> 16;
      v_nxt[i] = s2_one_r ? s2_a_r[i] : sat32(72'(s2_a_r[i]) + 72'(rsh[i]));
    end
    s3_nxt.kind = s2_kind_r;
    s3_nxt.none = s2_none_r;
    s3_nxt.cnt  = (s2_one_r || (s2_la_r > s2_lb_r)) ? s2_la_r : s2_lb_r;
    s3_nxt.v0   = v_nxt[0];
    s3_nxt.v1   = v_nxt[1];
    s3_nxt.v2   = v_nxt[2];
    s3_nxt.flip = 1'b0;
  end

  // ---------------------------------------------------------------- stage 3
  logic  v3_r;
  side_t s3_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      s3_r <= s3_nxt;
    end
  end

  // high part of the angle times reciprocal of 45
  logic signed [H_W-1:0] h_sig;
  logic [HU_W-1:0]       hu_nxt;
  logic [HP_W-1:0]       hp_nxt;

  always_comb begin
    h_sig  = s3_r.v0[VAL_W-1:LOW_W];
    hu_nxt = HU_W'(h_sig) + HU_W'(H_OFS);
    hp_nxt = HP_W'(hu_nxt) * HP_W'(RECIP);
  end

  // ---------------------------------------------------------------- stage 4
  logic             v4_r;
  side_t            s4_r;
  logic [HP_W-1:0]  s4_hp_r;
  logic [HU_W-1:0]  s4_hu_r;
  logic [LOW_W-1:0] s4_low_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      s4_r     <= s3_r;
      s4_hp_r  <= hp_nxt;
      s4_hu_r  <= hu_nxt;
      s4_low_r <= s3_r.v0[LOW_W-1:0];
    end
  end

  // remainder modulo 45 with one correction
  logic [HU_W-1:0] q45;
  logic [HU_W-1:0] rem0;
  logic [5:0]      rem_nxt;

  always_comb begin
    q45     = HU_W'(s4_hp_r >> RECIP_SH);
    rem0    = s4_hu_r - HU_W'(q45 * HU_W'(45));
    rem_nxt = (rem0 >= HU_W'(45)) ? 6'(rem0 - HU_W'(45)) : 6'(rem0);
  end

  // ---------------------------------------------------------------- stage 5
  logic             v5_r;
  side_t            s5_r;
  logic [5:0]       s5_rem_r;
  logic [LOW_W-1:0] s5_low_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      s5_r     <= s4_r;
      s5_rem_r <= rem_nxt;
      s5_low_r <= s4_low_r;
    end
  end

  // fold into [-90, 90] degrees
  logic [R0_W-1:0]  r0;
  logic [R0_W-1:0]  mag_w;
  logic             neg_nxt;
  logic             flip_nxt;
  side_t            s6_nxt;

  always_comb begin
    r0 = {s5_rem_r, s5_low_r};
    priority if (r0 <= DEG_90) begin
      mag_w    = r0;
      neg_nxt  = 1'b0;
      flip_nxt = 1'b0;
    end else if (r0 < DEG_270) begin
      neg_nxt  = (r0 > DEG_180);
      mag_w    = neg_nxt ? (r0 - DEG_180) : (DEG_180 - r0);
      flip_nxt = 1'b1;
    end else begin
      mag_w    = DEG_360 - r0;
      neg_nxt  = 1'b1;
      flip_nxt = 1'b0;
    end
    s6_nxt      = s5_r;
    s6_nxt.flip = flip_nxt;
  end

  // ---------------------------------------------------------------- stage 6
  logic             v6_r;
  side_t            s6_r;
  logic [MAG_W-1:0] s6_mag_r;
  logic             s6_neg_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      s6_r      <= s6_nxt;
      s6_mag_r  <= mag_w[MAG_W-1:0];
      s6_neg_r  <= neg_nxt;
    end
  end

  // degrees to radians
  logic [MM_W-1:0] mm_nxt;

  assign mm_nxt = MM_W'(s6_mag_r) * MM_W'(RAD_PER_DEG);

  // ---------------------------------------------------------------- stage 7
  logic            v7_r;
  side_t           s7_r;
  logic [MM_W-1:0] s7_mm_r;
  logic            s7_neg_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      s7_r     <= s6_r;
      s7_mm_r  <= mm_nxt;
      s7_neg_r <= s6_neg_r;
    end
  end

  // rounded angle in Q2.30
  logic [31:0]              zm;
  logic signed [TRIG_W-1:0] z_nxt;

  always_comb begin
    zm    = 32'((s7_mm_r + (MM_W'(1) << (FRAC_BITS + 1))) >> (FRAC_BITS + 2));
    z_nxt = s7_neg_r ? -$signed(TRIG_W'(zm)) : $signed(TRIG_W'(zm));
  end

  // ---------------------------------------------------------------- cordic
  logic [CORDIC_STEPS:0]    cv_r;
  logic signed [TRIG_W-1:0] cx_r [CORDIC_STEPS+1];
  logic signed [TRIG_W-1:0] cy_r [CORDIC_STEPS+1];
  logic signed [TRIG_W-1:0] cz_r [CORDIC_STEPS+1];
  side_t                    cs_r [CORDIC_STEPS+1];

  // cordic entry
  always_ff @(posedge clk) begin
    if (adv) begin
      cx_r[0] <= CORDIC_GAIN;
      cy_r[0] <= '0;
      cz_r[0] <= z_nxt;
      cs_r[0] <= s7_r;
    end
  end

  // one micro-rotation per stage
  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cordic
    always_ff @(posedge clk) begin
      if (adv) begin
        cs_r[i+1] <= cs_r[i];
        if (!cz_r[i][TRIG_W-1]) begin
          cx_r[i+1] <= cx_r[i] - (cy_r[i] >>> i);
          cy_r[i+1] <= cy_r[i] + (cx_r[i] >>> i);
          cz_r[i+1] <= cz_r[i] - atan_q30(i);
        end else begin
          cx_r[i+1] <= cx_r[i] + (cy_r[i] >>> i);
          cy_r[i+1] <= cy_r[i] - (cx_r[i] >>> i);
          cz_r[i+1] <= cz_r[i] + atan_q30(i);
        end
      end
    end
  end

  // sine, cosine and divider setup
  trig_t                    tg_nxt;
  logic [TRIG_W-1:0]        sa;
  logic [NUM_W-1:0]         num;

  always_comb begin
    tg_nxt.s30   = cy_r[CORDIC_STEPS];
    tg_nxt.c30   = cs_r[CORDIC_STEPS].flip ? -cx_r[CORDIC_STEPS] : cx_r[CORDIC_STEPS];
    tg_nxt.sneg  = tg_nxt.s30[TRIG_W-1];
    tg_nxt.qneg  = tg_nxt.s30[TRIG_W-1] ^ tg_nxt.c30[TRIG_W-1];
    sa           = tg_nxt.sneg ? TRIG_W'(-tg_nxt.s30) : TRIG_W'(tg_nxt.s30);
    tg_nxt.den   = tg_nxt.c30[TRIG_W-1] ? TRIG_W'(-tg_nxt.c30) : TRIG_W'(tg_nxt.c30);
    tg_nxt.czero = (tg_nxt.den == '0);
    tg_nxt.ovf   = (OV_W'(sa) >= (OV_W'(tg_nxt.den) << (QW - FRAC_BITS)));
    num          = NUM_W'(sa) << FRAC_BITS;
  end

  // ---------------------------------------------------------------- divider
  logic [QW:0]      dv_r;
  logic [DR_W-1:0]  dr_r [QW+1];
  logic [QW-1:0]    dn_r [QW+1];
  logic [QW-1:0]    dq_r [QW+1];
  trig_t            dt_r [QW+1];
  side_t            ds_r [QW+1];

  // divider entry
  always_ff @(posedge clk) begin
    if (adv) begin
      dr_r[0] <= DR_W'(num >> QW);
      dn_r[0] <= num[QW-1:0];
      dq_r[0] <= '0;
      dt_r[0] <= tg_nxt;
      ds_r[0] <= cs_r[CORDIC_STEPS];
    end
  end

  // one quotient bit per stage
  for (genvar j = 0; j < QW; j++) begin : g_div
    logic [DR_W-1:0] cand;
    logic            take;

    assign cand = {dr_r[j][DR_W-2:0], dn_r[j][QW-1]};
    assign take = (cand >= DR_W'(dt_r[j].den));

    always_ff @(posedge clk) begin
      if (adv) begin
        dr_r[j+1] <= take ? (cand - DR_W'(dt_r[j].den)) : cand;
        dn_r[j+1] <= {dn_r[j][QW-2:0], 1'b0};
        dq_r[j+1] <= {dq_r[j][QW-2:0], take};
        dt_r[j+1] <= dt_r[j];
        ds_r[j+1] <= ds_r[j];
      end
    end
  end

  // rotation terms, tangent and products
  trig_t                    dt;
  side_t                    ds;
  logic signed [31:0]       m0_nxt;
  logic signed [31:0]       m1_nxt;
  logic signed [31:0]       tan_nxt;
  logic signed [31:0]       qs;

  always_comb begin
    dt     = dt_r[QW];
    ds     = ds_r[QW];
    m0_nxt = sat32(72'((dt.c30 + TRIG_HALF) >>> (30 - FRAC_BITS)));
    m1_nxt = sat32(72'((dt.s30 + TRIG_HALF) >>> (30 - FRAC_BITS)));
    qs     = $signed({1'b0, dq_r[QW]});
    priority if (dt.czero) begin
      tan_nxt = dt.sneg ? S32_MIN : S32_MAX;
    end else if (dt.ovf) begin
      tan_nxt = dt.qneg ? S32_MIN : S32_MAX;
    end else begin
      tan_nxt = dt.qneg ? -qs : qs;
    end
  end

  // ---------------------------------------------------------------- final 1
  logic                     f1_v_r;
  side_t                    f1_s_r;
  logic signed [31:0]       f1_m0_r;
  logic signed [31:0]       f1_m1_r;
  logic signed [31:0]       f1_tan_r;
  logic signed [PROD_W-1:0] f1_p1_r;
  logic signed [PROD_W-1:0] f1_p2_r;
  logic signed [PROD_W-1:0] f1_p3_r;
  logic signed [PROD_W-1:0] f1_p4_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      f1_s_r   <= ds;
      f1_m0_r  <= m0_nxt;
      f1_m1_r  <= m1_nxt;
      f1_tan_r <= tan_nxt;
      f1_p1_r  <= dt.s30 * ds.v2;
      f1_p2_r  <= dt.c30 * ds.v1;
      f1_p3_r  <= dt.s30 * ds.v1;
      f1_p4_r  <= dt.c30 * ds.v2;
    end
  end

  // rotate translation and matrix select
  logic signed [PROD_W:0] acc4;
  logic signed [PROD_W:0] acc5;
  logic signed [31:0]     m4;
  logic signed [31:0]     m5;
  logic signed [31:0]     ma_nxt, mb_nxt, mc_nxt, md_nxt, me_nxt, mf_nxt;

  always_comb begin
    acc4 = (PROD_W+1)'(f1_p1_r) - (PROD_W+1)'(f1_p2_r);
    acc5 = -(PROD_W+1)'(f1_p3_r) - (PROD_W+1)'(f1_p4_r);
    m4   = sat32(72'(f1_s_r.v1) + 72'((acc4 + 67'sd536870912) >>> 30));
    m5   = sat32(72'(f1_s_r.v2) + 72'((acc5 + 67'sd536870912) >>> 30));
    ma_nxt = FX_ONE;
    mb_nxt = '0;
    mc_nxt = '0;
    md_nxt = FX_ONE;
    me_nxt = '0;
    mf_nxt = '0;
    if (!f1_s_r.none) begin
      case (f1_s_r.kind)
        KIND_TRANSLATE: begin
          me_nxt = f1_s_r.v0;
          mf_nxt = f1_s_r.v1;
        end
        KIND_SCALE: begin
          if (f1_s_r.cnt != 2'd0) begin
            ma_nxt = f1_s_r.v0;
            md_nxt = (f1_s_r.cnt > 2'd1) ? f1_s_r.v1 : f1_s_r.v0;
          end
        end
        KIND_ROTATE: begin
          ma_nxt = f1_m0_r;
          mb_nxt = f1_m1_r;
          mc_nxt = sat32(-72'(f1_m1_r));
          md_nxt = f1_m0_r;
          me_nxt = m4;
          mf_nxt = m5;
        end
        KIND_SKEW_X: mc_nxt = f1_tan_r;
        KIND_SKEW_Y: mb_nxt = f1_tan_r;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------- output
  logic signed [31:0] mat_a_r, mat_b_r, mat_c_r, mat_d_r, mat_e_r, mat_f_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      mat_a_r <= ma_nxt;
      mat_b_r <= mb_nxt;
      mat_c_r <= mc_nxt;
      mat_d_r <= md_nxt;
      mat_e_r <= me_nxt;
      mat_f_r <= mf_nxt;
    end
  end

  // valid chain
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      v4_r        <= 1'b0;
      v5_r        <= 1'b0;
      v6_r        <= 1'b0;
      v7_r        <= 1'b0;
      cv_r        <= '0;
      dv_r        <= '0;
      f1_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      v1_r        <= v1_nxt;
      v2_r        <= v1_r;
      v3_r        <= v2_r;
      v4_r        <= v3_r;
      v5_r        <= v4_r;
      v6_r        <= v5_r;
      v7_r        <= v6_r;
      cv_r        <= {cv_r[CORDIC_STEPS-1:0], v7_r};
      dv_r        <= {dv_r[QW-1:0], cv_r[CORDIC_STEPS]};
      f1_v_r      <= dv_r[QW];
      out_valid_r <= f1_v_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_mat_a = mat_a_r;
  assign out_mat_b = mat_b_r;
  assign out_mat_c = mat_c_r;
  assign out_mat_d = mat_d_r;
  assign out_mat_e = mat_e_r;
  assign out_mat_f = mat_f_r;

  // checks
  `KFAT_ASSERT_NXT(a_write_no_result, in_valid && in_ready && (in_req_type == REQ_WRITE), !v1_r, "write item entered the evaluate pipeline")
  `KFAT_ASSERT_NXT(a_hold_result, out_valid_r && !out_ready, out_valid_r && $stable(mat_a_r), "waiting result changed")
  `KFAT_ASSERT_NXT(a_stall_freeze, !adv, $stable({v1_r, v2_r, v3_r, v4_r, v5_r, v6_r, v7_r, cv_r, dv_r, f1_v_r}), "pipeline moved during stall")

endmodule

// ----- bench/tb_top.sv -----
// self-checking bench for the keyframe affine transform generator
`timescale 1ns / 100ps
module tb_top;
  import kfat_pkg::*;

  typedef struct {
    logic        req;
    logic [3:0]  slot;
    logic [1:0]  cnt;
    int          val [3];
    logic [16:0] prog;
  } kf_item_t;

  typedef struct {
    int m [6];
  } matrix_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic cfg_index = CFG_KIND;
  logic [4:0] cfg_wdata = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic in_req_type = REQ_WRITE;
  logic [3:0] in_key_index = '0;
  logic [1:0] in_value_count = '0;
  logic signed [31:0] in_value_first = '0;
  logic signed [31:0] in_value_second = '0;
  logic signed [31:0] in_value_third = '0;
  logic [16:0] in_progress = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [31:0] out_mat_a, out_mat_b, out_mat_c, out_mat_d, out_mat_e, out_mat_f;

  keyframe_affine_transform_gen dut (.*);

  // clock and timeout
  initial begin
    forever #1 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("tb_top: FAIL");
    $finish;
  end

  // shadow copy of the block's table and registers
  logic [2:0] shadow_kind = 3'd0;
  logic [4:0] shadow_nkey = 5'd0;
  int shadow_vals [48];
  logic [1:0] shadow_lens [16];

  kf_item_t pend [$];
  matrix_t  matrix_q [$];
  int  errors = 0;
  bit  idle_on = 1'b1;

  const longint ATAN_TAB [24] = '{
    64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6, 64'h03FEAB76, 64'h01FFD55B,
    64'h00FFFAAA, 64'h007FFF55, 64'h003FFFEA, 64'h001FFFFD, 64'h000FFFFF, 64'h0007FFFF,
    64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF, 64'h00007FFF, 64'h00003FFF, 64'h00001FFF,
    64'h00000FFF, 64'h000007FF, 64'h000003FF, 64'h000001FF, 64'h000000FF, 64'h0000007F};

  function automatic int clip32(longint v);
    if (v > 64'sd2147483647) return 32'sh7FFFFFFF;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return int'(v);
  endfunction

  function automatic longint round_shr(longint v, int s);
    return (v + (64'sd1 <<< (s - 1))) >>> s;
  endfunction

  // fold the angle to [-90, 90] degrees, then rotate a cordic vector in Q2.30
  function automatic void angle_trig(longint deg, output longint s30, output longint c30);
    longint period, quarter, r, z, x, y, dx, dy;
    longint unsigned mag, deg_rad;
    bit flip;
    period = 64'sd360 <<< 16;
    quarter = 64'sd90 <<< 16;
    deg_rad = (64'h3243F6A8885A308D + (64'd90 << 28)) / (64'd180 << 28);
    flip = 1'b0;
    r = deg % period;
    if (r < 0) r += period;
    if (r >= period / 2) r -= period;
    if (r > quarter) begin
      r = 2 * quarter - r;
      flip = 1'b1;
    end else if (r < -quarter) begin
      r = -2 * quarter - r;
      flip = 1'b1;
    end
    mag = longint'(r < 0 ? -r : r) * deg_rad;
    mag = (mag + (64'd1 << 17)) >> 18;
    z = r < 0 ? -longint'(mag) : longint'(mag);
    x = 64'sh26DD3B6A;
    y = 0;
    for (int i = 0; i < 24; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= ATAN_TAB[i];
      end else begin
        x += dx; y -= dy; z += ATAN_TAB[i];
      end
    end
    s30 = y;
    c30 = flip ? -x : x;
  endfunction

  function automatic int skew_tan(longint deg);
    longint s, c;
    angle_trig(deg, s, c);
    if (c == 0) return s >= 0 ? 32'sh7FFFFFFF : 32'sh80000000;
    return clip32((s <<< 16) / c);
  endfunction

  // apply one accepted item to the shadow table, queue the matrix it yields
  task automatic apply_item(kf_item_t it);
    matrix_t mt;
    int v [3];
    int n, cnt, idx, segs;
    longint sp, t, a, b, s30, c30, acc;
    if (it.req == REQ_WRITE) begin
      shadow_lens[it.slot] = it.cnt;
      for (int i = 0; i < 3; i++) shadow_vals[it.slot * 3 + i] = i < it.cnt ? it.val[i] : 0;
      return;
    end
    mt.m = '{FX_ONE, 0, 0, FX_ONE, 0, 0};
    v = '{0, 0, 0};
    cnt = 0;
    n = shadow_nkey > MAX_KEYFRAMES ? MAX_KEYFRAMES : shadow_nkey;
    if (n > 0) begin
      if (n == 1) begin
        for (int i = 0; i < 3; i++) v[i] = shadow_vals[i];
        cnt = shadow_lens[0];
      end else begin
        segs = n - 1;
        sp = longint'(it.prog) * segs;
        idx = int'(sp >> 16);
        if (idx > segs - 1) idx = segs - 1;
        t = sp - (longint'(idx) << 16);
        for (int i = 0; i < 3; i++) begin
          a = shadow_vals[idx * 3 + i];
          b = shadow_vals[(idx + 1) * 3 + i];
          v[i] = clip32(a + round_shr((b - a) * t, 16));
        end
        cnt = shadow_lens[idx] > shadow_lens[idx + 1] ? shadow_lens[idx] : shadow_lens[idx + 1];
      end
      case (shadow_kind)
        KIND_TRANSLATE: begin
          mt.m[4] = v[0];
          mt.m[5] = v[1];
        end
        KIND_SCALE: begin
          if (cnt != 0) begin
            mt.m[0] = v[0];
            mt.m[3] = cnt > 1 ? v[1] : v[0];
          end
        end
        KIND_ROTATE: begin
          angle_trig(v[0], s30, c30);
          mt.m[0] = clip32(round_shr(c30, 14));
          mt.m[1] = clip32(round_shr(s30, 14));
          mt.m[2] = clip32(-longint'(mt.m[1]));
          mt.m[3] = mt.m[0];
          acc = s30 * v[2] - c30 * v[1];
          mt.m[4] = clip32(longint'(v[1]) + round_shr(acc, 30));
          acc = -(s30 * v[1]) - c30 * v[2];
          mt.m[5] = clip32(longint'(v[2]) + round_shr(acc, 30));
        end
        KIND_SKEW_X: mt.m[2] = skew_tan(v[0]);
        KIND_SKEW_Y: mt.m[1] = skew_tan(v[0]);
        default: ;
      endcase
    end
    matrix_q.insert(matrix_q.size(), mt);
  endtask

  // item driver with random gaps
  int send_gap = 0;
  kf_item_t cur;
  always @(posedge clk) begin
    bit busy;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      busy = in_valid;
      if (in_valid && in_ready) begin
        apply_item(cur);
        busy = 1'b0;
      end
      if (!busy) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (pend.size() > 0) begin
          cur = pend.pop_front();
          in_req_type <= cur.req;
          in_key_index <= cur.slot;
          in_value_count <= cur.cnt;
          in_value_first <= cur.val[0];
          in_value_second <= cur.val[1];
          in_value_third <= cur.val[2];
          in_progress <= cur.prog;
          in_valid <= 1'b1;
          send_gap = idle_on ? $urandom_range(0, 13) : 0;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result monitor with random back-pressure
  int recv_stall = 0;
  always @(posedge clk) begin
    matrix_t mt;
    logic signed [31:0] got [6];
    string names [6];
    names = '{"mat_a", "mat_b", "mat_c", "mat_d", "mat_e", "mat_f"};
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        got = '{out_mat_a, out_mat_b, out_mat_c, out_mat_d, out_mat_e, out_mat_f};
        if (matrix_q.size() == 0) begin
          $error("unexpected result item");
          errors++;
        end else begin
          mt = matrix_q.pop_front();
          for (int i = 0; i < 6; i++)
            if (got[i] !== mt.m[i]) begin
              $error("%s: expected %0d, got %0d", names[i], mt.m[i], got[i]);
              errors++;
            end
        end
        recv_stall = idle_on ? $urandom_range(0, 13) : 0;
      end
      if (recv_stall > 0) begin
        recv_stall--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // random value: full range, angles, right angles, extremes, tiny values or mid-range values
  function automatic int pick_value();
    case ($urandom_range(0, 5))
      0: return $urandom();
      1: return ($urandom_range(0, 1440) - 720) <<< 16;
      2: return (($urandom_range(0, 8) - 4) * 90) <<< 16;
      3: return $urandom_range(0, 1) ? 32'sh7FFFFFFF : 32'sh80000000;
      4: return $urandom_range(0, 1) ? int'($urandom_range(0, 3)) : -int'($urandom_range(0, 3));
      default: return (int'($urandom_range(0, 8192)) - 4096) <<< 8;
    endcase
  endfunction

  function automatic kf_item_t make_item(logic req);
    kf_item_t it;
    it.req = req;
    it.slot = 4'($urandom_range(0, 15));
    it.cnt = 2'($urandom_range(0, 3));
    for (int i = 0; i < 3; i++) it.val[i] = pick_value();
    case ($urandom_range(0, 4))
      0: it.prog = 17'd0;
      1: it.prog = 17'd65536;
      default: it.prog = 17'($urandom_range(0, 65536));
    endcase
    return it;
  endfunction

  // wait until nothing is queued, driven or awaited, checked between edges
  task automatic wait_drained();
    do @(negedge clk);
    while (!(pend.size() == 0 && !in_valid && matrix_q.size() == 0));
  endtask

  // register writes happen only with the block drained
  task automatic write_reg(logic idx, logic [4:0] data);
    wait_drained();
    repeat (80) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_KIND) shadow_kind = data[2:0];
    else shadow_nkey = data;
  endtask

  // stimulus
  initial begin
    kf_item_t it;
    logic [2:0] kinds [6];
    logic [4:0] nkeys [6];
    kinds = '{KIND_TRANSLATE, KIND_SCALE, KIND_ROTATE, KIND_SKEW_X, KIND_SKEW_Y, 3'd7};
    nkeys = '{5'd0, 5'd1, 5'd16, 5'd31, 5'd2, 5'd3};
    for (int i = 0; i < 48; i++) shadow_vals[i] = 0;
    for (int i = 0; i < 16; i++) shadow_lens[i] = '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // fill every slot first so no evaluation reads an unwritten one
    for (int s = 0; s < 16; s++) begin
      it = make_item(REQ_WRITE);
      it.slot = 4'(s);
      it.cnt = 2'(s % 4);
      if (s == 0) it.val = '{90 <<< 16, 32'sh7FFFFFFF, 32'sh80000000};
      if (s == 1) it.val = '{-90 <<< 16, 32'sh80000000, 32'sh7FFFFFFF};
      pend.insert(pend.size(), it);
    end

    // directed settings with a few evaluations each
    for (int p = 0; p < 6; p++) begin
      write_reg(CFG_KIND, {2'b00, kinds[p]});
      write_reg(CFG_NKEY, nkeys[p]);
      it = make_item(REQ_EVAL);
      it.prog = 17'd0;
      pend.insert(pend.size(), it);
      it.prog = 17'd65536;
      pend.insert(pend.size(), it);
    end

    // random phases, well-formed table updates mixed with evaluations
    for (int p = 0; p < 12; p++) begin
      idle_on = (p % 4) != 3;
      write_reg(CFG_KIND, 5'($urandom_range(0, 9) == 0 ? $urandom_range(5, 7)
                                                       : $urandom_range(0, 4)));
      case ($urandom_range(0, 5))
        0: write_reg(CFG_NKEY, 5'($urandom_range(0, 31)));
        1: write_reg(CFG_NKEY, 5'($urandom_range(0, 1)));
        default: write_reg(CFG_NKEY, 5'($urandom_range(2, 16)));
      endcase
      for (int k = 0; k < 40; k++)
        pend.insert(pend.size(), make_item($urandom_range(0, 3) == 0 ? REQ_WRITE : REQ_EVAL));
    end

    wait_drained();
    repeat (80) @(posedge clk);
    if (errors == 0 && matrix_q.size() == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+design
design/kfat_pkg.sv
design/kfat_ram.sv
design/keyframe_affine_transform_gen.sv
bench/tb_top.sv
